### src/bblur_pkg.sv
package bblur_pkg;

	// pixel and channel widths
	localparam int unsigned CH_W  = 8;
	localparam int unsigned PIX_W = 3 * CH_W;

	// a sum of up to nine channel values, and the count of pixels in it
	localparam int unsigned SUM_W = 12;
	localparam int unsigned CNT_W = 4;

	// configuration port
	localparam int unsigned IMG_W_W   = 11;
	localparam int unsigned IMG_H_W   = 16;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// request codes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// job queue between front and back
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

	// one neighbourhood to be averaged
	typedef struct packed {
		logic [SUM_W-1:0] sum_r;
		logic [SUM_W-1:0] sum_g;
		logic [SUM_W-1:0] sum_b;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} job_t;

endpackage

### src/bblur_queue.sv
module bblur_queue
	import bblur_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	job_t                 slots_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (count_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (Q_PTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (Q_PTR_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

### src/bblur_front.sv
module bblur_front
	import bblur_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024,
	localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               restart,
	input  logic [COL_W-1:0]   w_last,
	input  logic [IMG_H_W-1:0] h_eff,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [CH_W-1:0]    in_red,
	input  logic [CH_W-1:0]    in_green,
	input  logic [CH_W-1:0]    in_blue,
	output logic               job_valid,
	output job_t               job,
	input  logic               q_full
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PIX   = 6'b000010,
		S_EMA   = 6'b000100,
		S_EMB   = 6'b001000,
		S_FACC  = 6'b010000,
		S_FPUSH = 6'b100000
	} fe_state_t;

	fe_state_t                 state_q;
	logic [COL_W-1:0]          in_col_q;
	logic [IMG_H_W-1:0]        in_row_q;
	logic [COL_W-1:0]          out_col_q;
	logic [IMG_H_W-1:0]        out_row_q;
	logic [8:0][PIX_W-1:0]     win_q;

	logic [PIX_W-1:0]          older_mem [MAX_WIDTH];
	logic [PIX_W-1:0]          newer_mem [MAX_WIDTH];
	logic [PIX_W-1:0]          rd_old_q;
	logic [PIX_W-1:0]          rd_new_q;

	logic [PIX_W-1:0]          pix_q;
	logic [COL_W-1:0]          x_q;
	logic                      need_a_q;
	logic                      need_b_q;
	logic                      row0_q;
	logic                      xge1_q;
	logic                      xge2_q;
	logic [COL_W-1:0]          fl_col_q;
	logic [COL_W-1:0]          fl_hi_q;
	logic [COL_W-1:0]          fl_c_q;
	job_t                      acc_q;

	logic [COL_W-1:0]          x;
	logic [COL_W-1:0]          c;
	logic [COL_W-1:0]          lo;
	logic [COL_W-1:0]          hi;
	logic [COL_W-1:0]          rd_addr;
	logic                      two_rows;
	logic                      pix_ok;
	logic                      flush_ok;
	logic                      idle;
	logic                      push_ok;
	logic [PIX_W-1:0]          old_m;
	job_t                      job_a;
	job_t                      job_b;

	// sum the enabled cells of the window; rows 1 and 2 and column 2 always count
	function automatic job_t win_sum(
		input logic [8:0][PIX_W-1:0] w,
		input logic                  row0_en,
		input logic                  col0_en,
		input logic                  col1_en
	);
		job_t j;
		logic en;
		j = '0;
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				en = (r != 0 || row0_en) &&
					(k == 2 || (k == 1 && col1_en) || (k == 0 && col0_en));
				if (en) begin
					j.sum_r = j.sum_r + SUM_W'(w[r*3+k][PIX_W-1:2*CH_W]);
					j.sum_g = j.sum_g + SUM_W'(w[r*3+k][2*CH_W-1:CH_W]);
					j.sum_b = j.sum_b + SUM_W'(w[r*3+k][CH_W-1:0]);
					j.cnt   = j.cnt + CNT_W'(1);
				end
			end
		end
		return j;
	endfunction

	assign idle     = (state_q == S_IDLE);
	assign in_stall = !idle;

	assign x        = (in_col_q > w_last) ? w_last : in_col_q;
	assign c        = (out_col_q > w_last) ? w_last : out_col_q;
	assign lo       = (c != '0) ? c - COL_W'(1) : c;
	assign hi       = (c < w_last) ? c + COL_W'(1) : c;
	assign two_rows = (h_eff > IMG_H_W'(1));
	assign pix_ok   = (in_row_q < h_eff);
	assign flush_ok = (in_row_q >= h_eff) && (out_row_q < h_eff);

	always_comb begin
		if (idle) begin
			rd_addr = (op == OP_FLUSH) ? lo : x;
		end else begin
			rd_addr = fl_col_q + COL_W'(1);
		end
	end

	assign old_m = two_rows ? rd_old_q : '0;

	always_comb begin
		job_a      = win_sum(win_q, row0_q, xge2_q, 1'b1);
		job_a.last = 1'b0;
		job_b      = win_sum(win_q, row0_q, 1'b0, xge1_q);
		job_b.last = 1'b0;
	end

	assign push_ok   = (state_q == S_EMA || state_q == S_EMB || state_q == S_FPUSH) && !q_full;
	assign job_valid = push_ok;

	always_comb begin
		priority case (1'b1)
			state_q == S_EMA: job = job_a;
			state_q == S_EMB: job = job_b;
			default:          job = acc_q;
		endcase
	end

	// line stores: read every cycle, write while the window takes the new column
	always_ff @(posedge clk) begin
		rd_old_q <= older_mem[rd_addr];
		rd_new_q <= newer_mem[rd_addr];
		if (state_q == S_PIX) begin
			older_mem[x_q] <= rd_new_q;
			newer_mem[x_q] <= pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			win_q     <= '0;
		end else if (restart) begin
			state_q   <= S_IDLE;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			win_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (op == OP_PIXEL) begin
							if (pix_ok) begin
								state_q <= S_PIX;
								if (x == w_last) begin
									in_col_q <= '0;
									in_row_q <= in_row_q + IMG_H_W'(1);
								end else begin
									in_col_q <= x + COL_W'(1);
								end
							end
						end else if (flush_ok) begin
							state_q <= S_FACC;
						end
					end
				end
				S_PIX: begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2] <= rd_old_q;
					win_q[3] <= win_q[4];
					win_q[4] <= win_q[5];
					win_q[5] <= rd_new_q;
					win_q[6] <= win_q[7];
					win_q[7] <= win_q[8];
					win_q[8] <= pix_q;
					if (need_a_q) begin
						state_q <= S_EMA;
					end else if (need_b_q) begin
						state_q <= S_EMB;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMA, S_EMB: begin
					if (!q_full) begin
						if (out_col_q == w_last) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + IMG_H_W'(1);
						end else begin
							out_col_q <= out_col_q + COL_W'(1);
						end
						state_q <= (state_q == S_EMA && need_b_q) ? S_EMB : S_IDLE;
					end
				end
				S_FACC: begin
					if (fl_col_q == fl_hi_q) begin
						state_q <= S_FPUSH;
					end
				end
				S_FPUSH: begin
					if (!q_full) begin
						if (fl_c_q == w_last) begin
							out_col_q <= '0;
							out_row_q <= out_row_q + IMG_H_W'(1);
						end else begin
							out_col_q <= fl_c_q + COL_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request details and the flush accumulator
	always_ff @(posedge clk) begin
		if (idle && in_valid) begin
			pix_q       <= {in_red, in_green, in_blue};
			x_q         <= x;
			need_a_q    <= (in_row_q != '0) && (x != '0);
			need_b_q    <= (in_row_q != '0) && (x == w_last);
			row0_q      <= (in_row_q >= IMG_H_W'(2));
			xge1_q      <= (x != '0);
			xge2_q      <= (x > COL_W'(1));
			fl_col_q    <= lo;
			fl_hi_q     <= hi;
			fl_c_q      <= c;
			acc_q.sum_r <= '0;
			acc_q.sum_g <= '0;
			acc_q.sum_b <= '0;
			acc_q.cnt   <= '0;
			acc_q.last  <= (c == w_last);
		end else if (state_q == S_FACC) begin
			acc_q.sum_r <= acc_q.sum_r + SUM_W'(rd_new_q[PIX_W-1:2*CH_W])
				+ SUM_W'(old_m[PIX_W-1:2*CH_W]);
			acc_q.sum_g <= acc_q.sum_g + SUM_W'(rd_new_q[2*CH_W-1:CH_W])
				+ SUM_W'(old_m[2*CH_W-1:CH_W]);
			acc_q.sum_b <= acc_q.sum_b + SUM_W'(rd_new_q[CH_W-1:0])
				+ SUM_W'(old_m[CH_W-1:0]);
			acc_q.cnt   <= acc_q.cnt + (two_rows ? CNT_W'(2) : CNT_W'(1));
			fl_col_q    <= fl_col_q + COL_W'(1);
		end
	end

endmodule

### src/bblur_back.sv
module bblur_back
	import bblur_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  job_t            q_job,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [CH_W-1:0] out_red,
	output logic [CH_W-1:0] out_green,
	output logic [CH_W-1:0] out_blue,
	output logic            frame_last
);

	localparam logic [CNT_W-1:0] DIV_ONE   = CNT_W'(1);
	localparam logic [CNT_W-1:0] DIV_TWO   = CNT_W'(2);
	localparam logic [CNT_W-1:0] DIV_THREE = CNT_W'(3);
	localparam logic [CNT_W-1:0] DIV_FOUR  = CNT_W'(4);
	localparam logic [CNT_W-1:0] DIV_SIX   = CNT_W'(6);
	localparam logic [CNT_W-1:0] DIV_NINE  = CNT_W'(9);

	// reciprocals scaled by 2^13 and 2^14, rounded up
	localparam logic [SUM_W-1:0] RECIP_THREE    = SUM_W'(2731);
	localparam logic [SUM_W-1:0] RECIP_NINE     = SUM_W'(1821);
	localparam int unsigned      RECIP_THREE_SH = 13;
	localparam int unsigned      RECIP_NINE_SH  = 14;

	logic            out_valid_q;
	logic [CH_W-1:0] out_red_q;
	logic [CH_W-1:0] out_green_q;
	logic [CH_W-1:0] out_blue_q;
	logic            frame_last_q;
	logic            take;

	// floor((2s + n) / 2n) = floor((s + floor(n/2)) / n)
	function automatic logic [CH_W-1:0] box_mean(
		input logic [SUM_W-1:0] s,
		input logic [CNT_W-1:0] n
	);
		logic [SUM_W-1:0]   u;
		logic [SUM_W-1:0]   ua;
		logic [SUM_W-1:0]   m;
		logic [2*SUM_W-1:0] p;
		logic [SUM_W-1:0]   q;
		u  = s + SUM_W'(n >> 1);
		ua = (n == DIV_SIX) ? (u >> 1) : u;
		m  = (n == DIV_NINE) ? RECIP_NINE : RECIP_THREE;
		p  = (2*SUM_W)'(ua) * (2*SUM_W)'(m);
		unique case (n)
			DIV_ONE:           q = u;
			DIV_TWO:           q = u >> 1;
			DIV_FOUR:          q = u >> 2;
			DIV_THREE, DIV_SIX: q = SUM_W'(p >> RECIP_THREE_SH);
			DIV_NINE:          q = SUM_W'(p >> RECIP_NINE_SH);
			default:           q = u;
		endcase
		return q[CH_W-1:0];
	endfunction

	assign take  = !out_valid_q || !out_stall;
	assign q_pop = take && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_red_q    <= box_mean(q_job.sum_r, q_job.cnt);
			out_green_q  <= box_mean(q_job.sum_g, q_job.cnt);
			out_blue_q   <= box_mean(q_job.sum_b, q_job.cnt);
			frame_last_q <= q_job.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = out_red_q;
	assign out_green  = out_green_q;
	assign out_blue   = out_blue_q;
	assign frame_last = frame_last_q;

endmodule

### src/box_blur_3x3_edge_normalized.sv
// 3x3 box blur over an RGB frame streamed in raster order.
// Input channel: in_valid / in_stall with op, in_red, in_green, in_blue. A pixel
// request (op = 0) feeds the next frame position; a flush request (op = 1) sent
// after the last pixel releases one result of the bottom row. Pixels beyond the
// frame, early flushes and flushes after the final result are dropped.
// Output channel: out_valid / out_stall with out_red, out_green, out_blue and
// frame_last, which marks the bottom-right result. Each mean covers the
// neighbours inside the frame only and is rounded half up.
// Sequencing: the front state machine works on one request at a time. A pixel
// request passes a window-shift state and then one emit state per result it
// releases (0 to 2); a flush passes an accumulate state, which gathers one
// stored column per step (1 to 3), and then a push state. A full job queue
// holds the emit and push states. A dropped request leaves the front idle. Two
// line stores of MAX_WIDTH entries each have one read and one write port.
// A four-entry job queue and the output register part the two sides. The front
// raises in_stall while it works on a request; a stalled receiver holds its
// result in the back end and, once the queue is full, holds the front as well.
// Reset sets a 1x1 frame and clears counters and window; line stores are not
// cleared, as every entry is written in a frame before its value is used. Writing
// either register restarts the frame.
module box_blur_3x3_edge_normalized
	import bblur_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 op,
	input  logic [CH_W-1:0]      in_red,
	input  logic [CH_W-1:0]      in_green,
	input  logic [CH_W-1:0]      in_blue,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CH_W-1:0]      out_red,
	output logic [CH_W-1:0]      out_green,
	output logic [CH_W-1:0]      out_blue,
	output logic                 frame_last
);

	localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [IMG_W_W-1:0] image_width_q;
	logic [IMG_H_W-1:0] image_height_q;
	logic [COL_W-1:0]   w_last;
	logic [IMG_H_W-1:0] h_eff;

	logic               job_valid;
	job_t               job;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;
	job_t               q_job;

	// hold the frame size; any write restarts the frame in the front end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMG_W_W'(1);
			image_height_q <= IMG_H_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[IMG_H_W-1:0];
				default:          image_width_q  <= image_width_q;
			endcase
		end
	end

	// clamp the width into 1..MAX_WIDTH and keep the last column index
	always_comb begin
		if (image_width_q == '0) begin
			w_last = '0;
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_last = COL_W'(MAX_WIDTH - 1);
		end else begin
			w_last = COL_W'(image_width_q - IMG_W_W'(1));
		end
	end

	// a zero height counts as one row
	assign h_eff = (image_height_q == '0) ? IMG_H_W'(1) : image_height_q;

	bblur_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_wr_en),
		.w_last    (w_last),
		.h_eff     (h_eff),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.in_red    (in_red),
		.in_green  (in_green),
		.in_blue   (in_blue),
		.job_valid (job_valid),
		.job       (job),
		.q_full    (q_full)
	);

	bblur_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_valid),
		.push_job (job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (q_job),
		.empty    (q_empty)
	);

	bblur_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (q_job),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.frame_last (frame_last)
	);

endmodule

### bench/blur_checker.sv
`timescale 1ns / 100ps

module blur_checker
	import bblur_pkg::*;
#(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 op,
	input  logic [CH_W-1:0]      in_red,
	input  logic [CH_W-1:0]      in_green,
	input  logic [CH_W-1:0]      in_blue,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [CH_W-1:0]      out_red,
	input  logic [CH_W-1:0]      out_green,
	input  logic [CH_W-1:0]      out_blue,
	input  logic                 frame_last,
	output int unsigned          fail_count,
	output int unsigned          pending
);

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            last;
	} blurred_px_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
		logic [CNT_W-1:0] count;
	} chan_sum_t;

	logic [IMG_W_W-1:0] frame_w;
	logic [IMG_H_W-1:0] frame_h;
	logic [PIX_W-1:0]   row_older [MAX_WIDTH];
	logic [PIX_W-1:0]   row_newer [MAX_WIDTH];
	logic [PIX_W-1:0]   win [9];
	int unsigned        col_in, row_in, col_out, row_out;
	blurred_px_t        blur_due [$];

	function automatic int unsigned used_width();
		if (frame_w == 0)
			return 1;
		if (frame_w > MAX_WIDTH)
			return MAX_WIDTH;
		return frame_w;
	endfunction

	function automatic chan_sum_t add_px(chan_sum_t s, logic [PIX_W-1:0] px);
		s.red   += px[2*CH_W +: CH_W];
		s.green += px[CH_W +: CH_W];
		s.blue  += px[0 +: CH_W];
		s.count += 1;
		return s;
	endfunction

	// sum over window rows rlo..2 and columns clo..2
	function automatic chan_sum_t window_total(int unsigned rlo, int unsigned clo);
		chan_sum_t s;
		s = '0;
		for (int unsigned rr = rlo; rr < 3; rr++)
			for (int unsigned cc = clo; cc < 3; cc++)
				s = add_px(s, win[rr*3 + cc]);
		return s;
	endfunction

	// half-up rounding by exact integer division
	function automatic logic [CH_W-1:0] rounded_mean(logic [SUM_W-1:0] sum,
		logic [CNT_W-1:0] n);
		int unsigned d, t;
		d = (n == 0) ? 1 : n;
		t = sum;
		return CH_W'((2*t + d) / (2*d));
	endfunction

	task automatic queue_mean(chan_sum_t s, logic last);
		blur_due.push_back({rounded_mean(s.red, s.count), rounded_mean(s.green, s.count),
			rounded_mean(s.blue, s.count), last});
	endtask

	task automatic advance_out(int unsigned w);
		col_out++;
		if (col_out >= w) begin
			col_out = 0;
			row_out++;
		end
	endtask

	task automatic restart_frame();
		foreach (win[i])
			win[i] = '0;
		col_in  = 0;
		row_in  = 0;
		col_out = 0;
		row_out = 0;
	endtask

	task automatic predict_request(input logic op_v, input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		int unsigned      w, h, x, c, lo, hi, rlo;
		logic [PIX_W-1:0] above2, above1;
		chan_sum_t        s;
		w = used_width();
		h = (frame_h == 0) ? 1 : frame_h;
		if (op_v == OP_PIXEL) begin
			// drop pixels beyond the frame
			if (row_in >= h)
				return;
			x = (col_in >= w) ? w - 1 : col_in;
			above2 = row_older[x];
			above1 = row_newer[x];
			for (int unsigned i = 0; i < 3; i++) begin
				win[i*3]     = win[i*3 + 1];
				win[i*3 + 1] = win[i*3 + 2];
			end
			win[2] = above2;
			win[5] = above1;
			win[8] = {r, g, b};
			row_older[x] = above1;
			row_newer[x] = {r, g, b};
			if (row_in >= 1) begin
				rlo = (row_in >= 2) ? 0 : 1;
				if (x >= 1) begin
					queue_mean(window_total(rlo, (x >= 2) ? 0 : 1), 1'b0);
					advance_out(w);
				end
				// right edge: the last column leaves with its left neighbour
				if (x == w - 1) begin
					queue_mean(window_total(rlo, (x >= 1) ? 1 : 2), 1'b0);
					advance_out(w);
				end
			end
			col_in = x + 1;
			if (col_in >= w) begin
				col_in = 0;
				row_in++;
			end
		end else begin
			// drop early flushes and flushes after the final result
			if (row_in < h || row_out >= h)
				return;
			c  = (col_out >= w) ? w - 1 : col_out;
			lo = (c >= 1) ? c - 1 : c;
			hi = (c + 1 < w) ? c + 1 : c;
			s  = '0;
			for (int unsigned i = lo; i <= hi; i++) begin
				if (h >= 2)
					s = add_px(s, row_older[i]);
				s = add_px(s, row_newer[i]);
			end
			queue_mean(s, c == w - 1);
			col_out = c;
			advance_out(w);
		end
	endtask

	task automatic check_result();
		blurred_px_t want, got;
		got = {out_red, out_green, out_blue, frame_last};
		if (blur_due.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("unexpected result: r=%0d g=%0d b=%0d last=%0d",
					got.red, got.green, got.blue, got.last);
			return;
		end
		want = blur_due.pop_front();
		if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
			|| got.last !== want.last) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
					want.red, want.green, want.blue, want.last,
					got.red, got.green, got.blue, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w = 1;
			frame_h = 1;
			restart_frame();
			blur_due.delete();
			foreach (row_older[i]) begin
				row_older[i] = '0;
				row_newer[i] = '0;
			end
		end else begin
			// results leaving now can only belong to earlier requests
			if (out_valid && !out_stall)
				check_result();
			if (cfg_wr_en) begin
				if (cfg_index == REG_IMAGE_WIDTH)
					frame_w = cfg_data[IMG_W_W-1:0];
				else if (cfg_index == REG_IMAGE_HEIGHT)
					frame_h = cfg_data[IMG_H_W-1:0];
				restart_frame();
			end
			if (in_valid && !in_stall)
				predict_request(op, in_red, in_green, in_blue);
		end
		pending = blur_due.size();
	end

endmodule

### bench/tb_box_blur_3x3_edge_normalized.sv
`timescale 1ns / 100ps

module tb_box_blur_3x3_edge_normalized;
	import bblur_pkg::*;

	localparam int unsigned FRAME_MAX_W   = 1024;
	// random part: roughly this many requests that the block acts on
	localparam int unsigned RANDOM_ITEMS  = 450;
	// cycles to let a request without result finish before a register write
	localparam int unsigned SETTLE_CYCLES = 8;
	// cycles without any handshake before the run is declared hung
	localparam int unsigned QUIET_LIMIT   = 4000;

	typedef enum int unsigned {RX_FREE, RX_LIGHT, RX_HEAVY, RX_HOLD} rx_mode_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 op        = OP_PIXEL;
	logic [CH_W-1:0]      in_red    = '0;
	logic [CH_W-1:0]      in_green  = '0;
	logic [CH_W-1:0]      in_blue   = '0;
	logic                 out_stall = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic [CH_W-1:0]      out_red, out_green, out_blue;
	logic                 frame_last;

	int unsigned fail_count;
	int unsigned pending;

	int unsigned burst_left   = 0;
	int unsigned items_sent   = 0;
	int unsigned quiet_cycles = 0;
	int unsigned cur_w        = 1;
	int unsigned cur_h        = 1;
	rx_mode_t    rx_mode      = RX_FREE;
	int unsigned rx_run       = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	box_blur_3x3_edge_normalized #(
		.MAX_WIDTH (FRAME_MAX_W)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.frame_last (frame_last)
	);

	blur_checker #(
		.MAX_WIDTH (FRAME_MAX_W)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.frame_last (frame_last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver: pick a stall behaviour, keep it for a random run, then pick
	// again. Free runs give stretches with no back-pressure at all, holds
	// can fill the job queue and so keep in_stall raised for longer.
	always @(posedge clk) begin
		if (rx_run == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_run  = (rx_mode == RX_HOLD) ? $urandom_range(1, 40) : $urandom_range(1, 120);
		end else begin
			rx_run--;
		end
		case (rx_mode)
			RX_FREE:  out_stall <= 1'b0;
			RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:  out_stall <= 1'b1;
		endcase
	end

	// Watchdog: any handshake or register write counts as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Channel value for a given flavour of frame: full range, saturated,
	// tiny values that stress the half-up rounding, or values around mid-scale.
	function automatic logic [CH_W-1:0] pick_channel(int unsigned flavour);
		case (flavour)
			0:       return CH_W'($urandom);
			1:       return $urandom_range(0, 1) ? 8'd255 : 8'd0;
			2:       return CH_W'($urandom_range(0, 3));
			default: return CH_W'($urandom_range(120, 136));
		endcase
	endfunction

	// Offer one request and hold it until the block takes it. Runs in bursts:
	// when a burst is used up, drop valid for a random gap first. Stall is
	// sampled on the falling edge, where it is settled for the next rising edge.
	task automatic send_request(input logic op_v, input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		int unsigned gap;
		bit          granted;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 24);
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		op       <= op_v;
		in_red   <= r;
		in_green <= g;
		in_blue  <= b;
		do begin
			@(negedge clk);
			granted = !in_stall;
			@(posedge clk);
		end while (!granted);
	endtask

	task automatic send_flush();
		send_request(OP_FLUSH, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
	endtask

	// Hold the sender until every expected result has left, then give a
	// request that releases nothing time to work through the block.
	task automatic drain_to_idle();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes, only ever issued from the idle state.
	task automatic set_geometry(input bit do_w, input int unsigned w, input bit do_h,
		input int unsigned h);
		if (do_w) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= REG_IMAGE_WIDTH;
			cfg_data  <= CFG_W'(w);
			@(posedge clk);
			cur_w = w;
		end
		if (do_h) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= REG_IMAGE_HEIGHT;
			cfg_data  <= CFG_W'(h);
			@(posedge clk);
			cur_h = h;
		end
		cfg_wr_en <= 1'b0;
	endtask

	// One frame at the current geometry: the pixels in raster order with the
	// odd early flush thrown in, then one flush per bottom-row result and
	// sometimes a little junk after the end. A cut-short frame stops part way
	// through its pixels and is abandoned by the next register write.
	task automatic send_frame(input bit cut_short);
		int unsigned w, h, total, stop_at, flavour;
		w = (cur_w == 0) ? 1 : ((cur_w > FRAME_MAX_W) ? FRAME_MAX_W : cur_w);
		h = (cur_h == 0) ? 1 : cur_h;
		total   = w * h;
		stop_at = cut_short ? $urandom_range(0, total - 1) : total;
		flavour = $urandom_range(0, 3);
		for (int unsigned i = 0; i < stop_at; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_flush();
			// now and then hold off half way until the block has caught up
			if (i == total / 2 && $urandom_range(0, 4) == 0)
				drain_to_idle();
			send_request(OP_PIXEL, pick_channel(flavour), pick_channel(flavour),
				pick_channel(flavour));
			items_sent++;
		end
		if (!cut_short) begin
			for (int unsigned k = 0; k < w; k++) begin
				send_flush();
				items_sent++;
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					send_request(1'($urandom_range(0, 1)), CH_W'($urandom), CH_W'($urandom),
						CH_W'($urandom));
		end
	endtask

	initial begin
		int unsigned     new_w, new_h, pick, random_start;
		bit              do_w, do_h;
		logic [CH_W-1:0] r, g, b;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry is 1x1: an early flush is dropped, the lone pixel is
		// released by one flush as the final result, and anything after that is
		// dropped as well.
		send_flush();
		send_request(OP_PIXEL, 8'd255, 8'd0, 8'd170);
		items_sent++;
		send_flush();
		items_sent++;
		send_flush();
		send_request(OP_PIXEL, 8'd1, 8'd2, 8'd3);

		// zero width and zero height both fall back to one
		drain_to_idle();
		set_geometry(1'b1, 0, 1'b1, 0);
		send_request(OP_PIXEL, 8'd0, 8'd0, 8'd0);
		send_flush();
		items_sent += 2;

		// 3x3 frame: corners, edges and the centre give divisors of four, six
		// and nine; alternating 0/1 in green lands means exactly on the half
		// and checks the rounding direction
		drain_to_idle();
		set_geometry(1'b1, 3, 1'b1, 3);
		for (int unsigned k = 0; k < 9; k++) begin
			r = k[0] ? 8'd0 : 8'd255;
			g = CH_W'(k[0]);
			b = 8'd255 - CH_W'(k * 31);
			if (k == 4)
				send_flush();
			send_request(OP_PIXEL, r, g, b);
			items_sent++;
		end
		repeat (3) send_flush();
		items_sent += 3;

		// Widest setting: all width bits set clamps to the full line store and
		// all height bits give the tallest frame. Fill one whole row, step a few
		// pixels into the next to read it back, then abandon the frame.
		drain_to_idle();
		set_geometry(1'b1, 2047, 1'b1, 65535);
		for (int unsigned k = 0; k < FRAME_MAX_W + 6; k++) begin
			send_request(OP_PIXEL, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
			items_sent++;
		end

		// Random frames, mostly complete and small; some rewrite only one
		// register, some are cut short, a few use zero for a dimension.
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			pick  = $urandom_range(0, 19);
			new_w = (pick < 11) ? $urandom_range(1, 4) : (pick < 17) ? $urandom_range(5, 16)
				: (pick < 19) ? $urandom_range(17, 64) : 0;
			pick  = $urandom_range(0, 19);
			new_h = (pick < 13) ? $urandom_range(1, 4) : (pick < 18) ? $urandom_range(5, 12)
				: (pick < 19) ? 1 : 0;
			do_w = 1'b1;
			do_h = 1'b1;
			pick = $urandom_range(0, 7);
			if (pick == 0 && cur_h <= 12)
				do_h = 1'b0;
			else if (pick == 1 && cur_w <= 64)
				do_w = 1'b0;
			drain_to_idle();
			set_geometry(do_w, new_w, do_h, new_h);
			send_frame($urandom_range(0, 7) == 0);
		end

		// wait for the tail, then give the verdict
		drain_to_idle();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### box_blur_3x3_edge_normalized.f
src/bblur_pkg.sv
src/bblur_queue.sv
src/bblur_front.sv
src/bblur_back.sv
src/box_blur_3x3_edge_normalized.sv
bench/blur_checker.sv
bench/tb_box_blur_3x3_edge_normalized.sv
